/* hw/rtl/pwt_pkg.sv */
// Package for the two-level page walk unit with move-to-front TLB.
// Holds payload structs, codes, controller states and TLB sizing.
// No dependencies.
package pwt_pkg;

  localparam int TlbEntries = 64;
  localparam int TlbIdxW    = $clog2(TlbEntries);

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_RESPONSE  = 2'd1,
    OP_FLUSH     = 2'd2,
    OP_RESERVED  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_READ    = 3'd1,
    KIND_FAULT   = 3'd2,
    KIND_FLUSHED = 3'd3,
    KIND_BAD     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CFG_PROT   = 2'd0,
    CFG_PAGING = 2'd1,
    CFG_DIR    = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DIR   = 2'd1,
    PH_TABLE = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_OUT    = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] linear_addr;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic        tlb_hit;
    logic        fault_level;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch input transaction
    logic execute;   // apply TLB update and form result
  } pwt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dummy;
  } pwt_status_t;

endpackage

/* hw/rtl/pwt_datapath.sv */
// Datapath: TLB storage with move-to-front shift, walk registers, result build.
// Depends on pwt_pkg.
module pwt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pwt_pkg::pwt_cmd_t  cmd,
  input  pwt_pkg::in_item_t  in_item,
  input  logic               prot_en,
  input  logic               pg_en,
  input  logic [19:0]        dir_frame,
  output pwt_pkg::out_item_t result,
  output pwt_pkg::pwt_status_t status
);

  localparam int N = pwt_pkg::TlbEntries;
  localparam int W = pwt_pkg::TlbIdxW;

  logic [N-1:0]  valid_r, valid_nxt;
  logic [19:0]   vp_r [N];
  logic [19:0]   pp_r [N];
  logic [19:0]   vp_nxt [N];
  logic [19:0]   pp_nxt [N];
  pwt_pkg::in_item_t  item_r;
  pwt_pkg::phase_t    phase_r, phase_nxt;
  logic [31:0]        pend_r, pend_nxt;
  pwt_pkg::out_item_t res_r, res_nxt;

  // Match and first-free registered in lookup cycle.
  logic [N-1:0] hit_vec;
  logic         hit_r;
  logic [W-1:0] hit_idx_r, hit_idx;
  logic         free_r;
  logic [W-1:0] free_idx_r, free_idx;
  logic         any_hit, any_free;

  assign status.dummy = 1'b0;
  assign result = res_r;

  // Lookup: associative compare over all entries, priority encode.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = valid_r[i] && (vp_r[i] == item_r.linear_addr[31:12]);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = W'(i);
        any_hit = 1'b1;
      end
      if (!valid_r[i]) begin
        free_idx = W'(i);
        any_free = 1'b1;
      end
    end
  end

  // Execute: update state and form result.
  always_comb begin
    logic        trans;
    logic [19:0] fill_pp;
    trans     = prot_en && pg_en;
    fill_pp   = item_r.read_data[31:12];
    valid_nxt = valid_r;
    vp_nxt    = vp_r;
    pp_nxt    = pp_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    res_nxt   = '{kind: pwt_pkg::KIND_BAD, address: '0, tlb_hit: 1'b0, fault_level: 1'b0};
    unique case (pwt_pkg::opcode_t'(item_r.opcode))
      pwt_pkg::OP_TRANSLATE: begin
        if (phase_r != pwt_pkg::PH_IDLE) begin
          res_nxt.kind = pwt_pkg::KIND_BAD;
        end else if (!trans) begin
          res_nxt.kind    = pwt_pkg::KIND_DONE;
          res_nxt.address = item_r.linear_addr;
        end else if (hit_r) begin
          // Move hit entry to front.
          for (int i = 1; i < N; i++) begin
            if (W'(i) <= hit_idx_r) begin
              valid_nxt[i] = valid_r[i-1];
              vp_nxt[i]    = vp_r[i-1];
              pp_nxt[i]    = pp_r[i-1];
            end
          end
          valid_nxt[0]    = 1'b1;
          vp_nxt[0]       = vp_r[hit_idx_r];
          pp_nxt[0]       = pp_r[hit_idx_r];
          res_nxt.kind    = pwt_pkg::KIND_DONE;
          res_nxt.address = {pp_r[hit_idx_r], item_r.linear_addr[11:0]};
          res_nxt.tlb_hit = 1'b1;
        end else begin
          pend_nxt        = item_r.linear_addr;
          phase_nxt       = pwt_pkg::PH_DIR;
          res_nxt.kind    = pwt_pkg::KIND_READ;
          res_nxt.address = {dir_frame, item_r.linear_addr[31:22], 2'b00};
        end
      end
      pwt_pkg::OP_RESPONSE: begin
        if (phase_r == pwt_pkg::PH_DIR) begin
          if (!item_r.read_data[0]) begin
            phase_nxt       = pwt_pkg::PH_IDLE;
            res_nxt.kind    = pwt_pkg::KIND_FAULT;
            res_nxt.address = pend_r;
          end else begin
            phase_nxt       = pwt_pkg::PH_TABLE;
            res_nxt.kind    = pwt_pkg::KIND_READ;
            res_nxt.address = {item_r.read_data[31:12], pend_r[21:12], 2'b00};
          end
        end else if (phase_r == pwt_pkg::PH_TABLE) begin
          phase_nxt = pwt_pkg::PH_IDLE;
          if (!item_r.read_data[0]) begin
            res_nxt.kind        = pwt_pkg::KIND_FAULT;
            res_nxt.address     = pend_r;
            res_nxt.fault_level = 1'b1;
          end else begin
            if (free_r) begin
              valid_nxt[free_idx_r] = 1'b1;
              vp_nxt[free_idx_r]    = pend_r[31:12];
              pp_nxt[free_idx_r]    = fill_pp;
            end else begin
              for (int i = 1; i < N; i++) begin
                valid_nxt[i] = valid_r[i-1];
                vp_nxt[i]    = vp_r[i-1];
                pp_nxt[i]    = pp_r[i-1];
              end
              valid_nxt[0] = 1'b1;
              vp_nxt[0]    = pend_r[31:12];
              pp_nxt[0]    = fill_pp;
            end
            res_nxt.kind    = pwt_pkg::KIND_DONE;
            res_nxt.address = {fill_pp, pend_r[11:0]};
          end
        end
      end
      pwt_pkg::OP_FLUSH: begin
        valid_nxt    = '0;
        res_nxt.kind = pwt_pkg::KIND_FLUSHED;
      end
      default: res_nxt.kind = pwt_pkg::KIND_BAD;
    endcase
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      phase_r <= pwt_pkg::PH_IDLE;
      pend_r  <= '0;
    end else if (cmd.execute) begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    hit_r      <= any_hit;
    hit_idx_r  <= hit_idx;
    free_r     <= any_free;
    free_idx_r <= free_idx;
    if (cmd.execute) begin
      res_r <= res_nxt;
      for (int i = 0; i < N; i++) begin
        vp_r[i] <= vp_nxt[i];
        pp_r[i] <= pp_nxt[i];
      end
    end
  end

endmodule

/* hw/rtl/pwt_ctrl.sv */
// Controller: capture, lookup and execute sequencing plus output handshake.
// Depends on pwt_pkg.
module pwt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pwt_pkg::pwt_status_t status,
  output pwt_pkg::pwt_cmd_t   cmd
);

  pwt_pkg::state_t state_r, state_nxt;
  logic            outv_r, outv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwt_pkg::ST_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
  end

  // Next state: accept, lookup, then execute into the result register once it is free.
  always_comb begin
    state_nxt   = state_r;
    outv_nxt    = outv_r && out_stall;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      pwt_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = pwt_pkg::ST_LOOKUP;
      end
      pwt_pkg::ST_LOOKUP: state_nxt = pwt_pkg::ST_OUT;
      pwt_pkg::ST_OUT: begin
        if (!outv_nxt) begin
          cmd.execute = 1'b1;
          outv_nxt    = 1'b1;
          state_nxt   = pwt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pwt_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = outv_r;

  logic unused_st;
  assign unused_st = status.dummy;

endmodule

/* hw/rtl/two_level_page_walk_with_mtf_tlb_unit.sv */
// Top level of the page walk unit with move-to-front TLB.
// Depends on pwt_pkg, pwt_ctrl and pwt_datapath.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall   | in_item (opcode, linear_addr, read_data)
//   out_    | output    | out_valid/out_stall | out_item (kind, address, tlb_hit, fault_level)
//   cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// Each transaction passes capture, TLB compare, then update and result when output is free.
// The associative compare over all TLB entries sets the lookup cycle.
// A new transaction is taken while the previous result still waits in the output register.
// Synchronous reset clears TLB valid bits, walk phase, pending address, config and control.
module two_level_page_walk_with_mtf_tlb_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pwt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pwt_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_data
);

  logic        prot_r, pg_r;
  logic [19:0] dir_r;
  pwt_pkg::pwt_cmd_t    cmd;
  pwt_pkg::pwt_status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_r <= 1'b0;
      pg_r   <= 1'b0;
      dir_r  <= '0;
    end else if (cfg_we) begin
      unique case (pwt_pkg::cfg_idx_t'(cfg_index))
        pwt_pkg::CFG_PROT:   prot_r <= cfg_data[0];
        pwt_pkg::CFG_PAGING: pg_r   <= cfg_data[0];
        pwt_pkg::CFG_DIR:    dir_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  pwt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  pwt_datapath u_dp (
    .clk, .rst_n, .cmd, .in_item,
    .prot_en(prot_r), .pg_en(pg_r), .dir_frame(dir_r),
    .result(out_item), .status
  );

endmodule
